// ===== rtl/nipo_pkg.sv =====
package nipo_pkg;

    // Size of one client set and the widths that follow from it.
    localparam int MAX_CLIENTS = 64;
    localparam int IDX_W       = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int ID_W        = 16;

    // A stored entry holds the client's rank within its node group above its node id.
    // Ordering entries by this key gives the round-robin pull order directly.
    localparam int KEY_W       = IDX_W + ID_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LSCAN = 4'b0010,
        S_ESCAN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

endpackage

// ===== rtl/nipo_ram.sv =====
module nipo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/node_interleaved_pull_order.sv =====
// Loading: a client word holds s_ready low while the stored clients are scanned for its
// rank, so no new word is taken before the block is through with the last one.
// Ordering: each result takes one scan over the whole set plus its handshake.
// A dropped word (set already full, no mark) is discarded without being stored.
// Reset (aresetn low, synchronous) empties the set and returns the block to idle.
module node_interleaved_pull_order (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nipo_pkg::ID_W-1:0]  s_node_id,
    input  logic                       s_last_client,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nipo_pkg::IDX_W-1:0] m_client_index,
    output logic                       m_last_out
);

    import nipo_pkg::*;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             found_reg, found_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] emit_k_reg, emit_k_next;
    logic             m_valid_reg, m_valid_next;

    // Payload state.
    logic [ID_W-1:0]  id_reg, id_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] rank_reg, rank_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [KEY_W-1:0] last_key_reg, last_key_next;
    logic [IDX_W-1:0] m_idx_reg, m_idx_next;
    logic             m_last_reg, m_last_next;

    // RAM ports.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic             scan_issue;
    logic             scan_done;
    logic             key_above;
    logic             key_below;

    nipo_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_CLIENTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared scan sequencer: one read issued per cycle, data arriving in the next cycle.
    assign scan_issue = (scan_addr_reg < count_reg);
    assign scan_done  = !scan_issue && !rd_vld_reg;
    assign ram_raddr  = scan_addr_reg[IDX_W-1:0];

    // Shared comparator pair for the selection scan.
    assign key_above = first_reg || (ram_rdata > last_key_reg);
    assign key_below = !found_reg || (ram_rdata < best_key_reg);

    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_wdata = {rank_reg, id_reg};

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_client_index = m_idx_reg;
    assign m_last_out     = m_last_reg;

    // Sequencer for loading, rank counting, selection and emission.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        emit_k_next    = emit_k_reg;
        m_valid_next   = m_valid_reg;
        id_next        = id_reg;
        last_next      = last_reg;
        rank_next      = rank_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        last_key_next  = last_key_reg;
        m_idx_next     = m_idx_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;

        if (state_reg != S_IDLE && scan_issue) begin
            scan_addr_next = scan_addr_reg + CNT_W'(1);
            rd_vld_next    = 1'b1;
            rd_idx_next    = scan_addr_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    id_next        = s_node_id;
                    last_next      = s_last_client;
                    rank_next      = '0;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    first_next     = 1'b1;
                    emit_k_next    = '0;
                    if (count_reg < CNT_W'(MAX_CLIENTS)) begin
                        state_next = S_LSCAN;
                    end else if (s_last_client) begin
                        state_next = S_ESCAN;
                    end
                end
            end
            S_LSCAN: begin
                // Count earlier clients on the same node; that count is this client's round.
                if (rd_vld_reg && ram_rdata[ID_W-1:0] == id_reg) begin
                    rank_next = rank_reg + IDX_W'(1);
                end
                if (scan_done) begin
                    ram_we         = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    scan_addr_next = '0;
                    state_next     = last_reg ? S_ESCAN : S_IDLE;
                end
            end
            S_ESCAN: begin
                // Pick the smallest key strictly above the one emitted before.
                if (rd_vld_reg && key_above && key_below) begin
                    found_next    = 1'b1;
                    best_key_next = ram_rdata;
                    best_idx_next = rd_idx_reg;
                end
                if (scan_done) begin
                    m_valid_next  = 1'b1;
                    m_idx_next    = best_idx_reg;
                    m_last_next   = (emit_k_reg == count_reg - CNT_W'(1));
                    last_key_next = best_key_reg;
                    first_next    = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    m_valid_next   = 1'b0;
                    emit_k_next    = emit_k_reg + CNT_W'(1);
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    if (m_last_reg) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_ESCAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b1;
            emit_k_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            emit_k_reg    <= emit_k_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        last_reg     <= last_next;
        rank_reg     <= rank_next;
        rd_idx_reg   <= rd_idx_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        last_key_reg <= last_key_next;
        m_idx_reg    <= m_idx_next;
        m_last_reg   <= m_last_next;
    end

endmodule

// ===== bench/node_interleaved_pull_order_tb.sv =====
`timescale 1ns / 1ps

module node_interleaved_pull_order_tb;

    import nipo_pkg::*;

    // One input word as queued for the driver. Setting hold_for_drain makes the
    // driver wait until every predicted index has come out before offering it.
    typedef struct {
        logic [ID_W-1:0] node_id;
        logic            last_client;
        bit              hold_for_drain;
    } client_word_t;

    // One predicted entry of the pull order.
    typedef struct {
        logic [IDX_W-1:0] client_index;
        logic             last_out;
    } pull_slot_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ID_W-1:0]      s_node_id = '0;
    logic                 s_last_client = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_client_index;
    logic                 m_last_out;

    client_word_t         pending_words[$];
    pull_slot_t           pull_order_q[$];
    logic [ID_W-1:0]      set_node_ids[$];
    int                   mismatch_count = 0;
    logic                 word_taken = 1'b0;
    int unsigned          burst_left = 1;
    int unsigned          gap_left = 0;
    int unsigned          stall_mode = 0;
    int unsigned          stall_phase = 0;

    node_interleaved_pull_order u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_node_id      (s_node_id),
        .s_last_client  (s_last_client),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_client_index (m_client_index),
        .m_last_out     (m_last_out)
    );

    // Clock and a single reset at the start of the run.
    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Store one client and, on the marked word, work out the whole pull order.
    // Each client's rank is the number of earlier clients on the same node; the
    // order is then ascending by rank, and by node id within one rank.
    task automatic take_client(input logic [ID_W-1:0] node_id, input logic mark);
        int         rank[MAX_CLIENTS];
        bit         used[MAX_CLIENTS];
        int         n;
        int         pick;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] pick_key;
        pull_slot_t slot;
        if (set_node_ids.size() < MAX_CLIENTS)
            set_node_ids.push_back(node_id);
        if (!mark)
            return;
        n = set_node_ids.size();
        for (int i = 0; i < n; i++) begin
            rank[i] = 0;
            used[i] = 1'b0;
            for (int j = 0; j < i; j++)
                if (set_node_ids[j] == set_node_ids[i])
                    rank[i]++;
        end
        pick_key = '0;
        for (int k = 0; k < n; k++) begin
            pick = -1;
            for (int i = 0; i < n; i++) begin
                key = {rank[i][IDX_W-1:0], set_node_ids[i]};
                if (!used[i] && (pick < 0 || key < pick_key)) begin
                    pick = i;
                    pick_key = key;
                end
            end
            used[pick] = 1'b1;
            slot.client_index = pick[IDX_W-1:0];
            slot.last_out = (k == n - 1);
            pull_order_q.push_back(slot);
        end
        set_node_ids.delete();
    endtask

    task automatic queue_word(input logic [ID_W-1:0] node_id, input logic mark,
                              input bit hold);
        client_word_t w;
        w.node_id = node_id;
        w.last_client = mark;
        w.hold_for_drain = hold;
        pending_words.push_back(w);
    endtask

    // A set of n clients with the mark on the final one. Narrow pools give
    // many clients on the same node; wide ones give mostly distinct nodes.
    task automatic queue_random_set(input int n, input bit hold);
        int unsigned pool;
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        pool = $urandom_range(0, 3);
        base = ID_W'($urandom);
        for (int i = 0; i < n; i++) begin
            case (pool)
                0: id = base + ID_W'($urandom_range(0, 1));
                1: id = base + ID_W'($urandom_range(0, 3));
                2: id = ID_W'($urandom_range(0, 7) * 16'h2001);
                default: id = ID_W'($urandom);
            endcase
            queue_word(id, i == n - 1, hold && i == 0);
        end
    endtask

    // Input side: note each accepted word and feed it to the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                take_client(s_node_id, s_last_client);
        end
    end

    // Driver: bursts of words separated by random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !word_taken) begin
            // The offered word has not been taken yet; keep it steady.
        end else if (gap_left != 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].hold_for_drain && pull_order_q.size() != 0)) begin
            s_valid <= 1'b1;
            s_node_id <= pending_words[0].node_id;
            s_last_client <= pending_words[0].last_client;
            pending_words.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 20);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: randomly chosen stall modes, each held for a random span.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_phase <= $urandom_range(20, 80);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (stall_phase[2:0] != 3'd0);
            endcase
        end
    end

    // Monitor: compare every accepted index with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pull_order_q.size() == 0) begin
                $error("unexpected word: client_index %0d last_out %0b",
                       m_client_index, m_last_out);
                mismatch_count = mismatch_count + 1;
            end else begin
                if (m_client_index !== pull_order_q[0].client_index) begin
                    $error("client_index: expected %0d, actual %0d",
                           pull_order_q[0].client_index, m_client_index);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_last_out !== pull_order_q[0].last_out) begin
                    $error("last_out: expected %0b, actual %0b",
                           pull_order_q[0].last_out, m_last_out);
                    mismatch_count = mismatch_count + 1;
                end
                void'(pull_order_q.pop_front());
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int random_words;
        bit full_done;
        int n;

        // A set of one client, offered only once the block has nothing pending.
        queue_word(16'h0000, 1'b1, 1'b1);
        // Extreme ids mixed, every id bit at both values.
        queue_word(16'hFFFF, 1'b0, 1'b0);
        queue_word(16'h0000, 1'b0, 1'b0);
        queue_word(16'hFFFF, 1'b0, 1'b0);
        queue_word(16'h0000, 1'b0, 1'b0);
        queue_word(16'h5555, 1'b0, 1'b0);
        queue_word(16'hAAAA, 1'b1, 1'b0);
        // All clients on one node.
        for (int i = 0; i < 4; i++)
            queue_word(16'h1234, i == 3, 1'b0);
        // Distinct nodes arriving in descending order.
        for (int i = 0; i < 5; i++)
            queue_word(ID_W'(500 - 100 * i), i == 4, 1'b0);
        // Groups of uneven size, so later rounds skip used-up groups.
        queue_word(16'd3, 1'b0, 1'b0);
        queue_word(16'd3, 1'b0, 1'b0);
        queue_word(16'd9, 1'b0, 1'b0);
        queue_word(16'd3, 1'b0, 1'b0);
        queue_word(16'd9, 1'b0, 1'b0);
        queue_word(16'd1, 1'b0, 1'b0);
        queue_word(16'd3, 1'b1, 1'b0);

        // Random sets, with one full set whose extra words are dropped,
        // the last of them carrying the mark.
        random_words = 0;
        full_done = 1'b0;
        while (random_words < 105) begin
            if (!full_done && random_words >= 30) begin
                for (int i = 0; i < MAX_CLIENTS; i++)
                    queue_word(ID_W'($urandom_range(0, 5) * 16'h3333), 1'b0, i == 0);
                queue_word(ID_W'($urandom), 1'b0, 1'b0);
                queue_word(ID_W'($urandom), 1'b1, 1'b0);
                random_words += MAX_CLIENTS + 2;
                full_done = 1'b1;
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                 : $urandom_range(1, 12);
                queue_random_set(n, $urandom_range(0, 7) == 0);
                random_words += n;
            end
        end

        @(posedge aclk);
        while (pending_words.size() != 0 || s_valid)
            @(posedge aclk);
        while (pull_order_q.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && pull_order_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nipo_pkg.sv
rtl/nipo_ram.sv
rtl/node_interleaved_pull_order.sv
bench/node_interleaved_pull_order_tb.sv
